// ===== design/rotation_matrix_to_quaternion_top_assert.svh =====
// Assertion macros for the rotation matrix to quaternion block.
// Used by the checker module; needs a clock and reset named clock and reset.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define RMQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmq assertion failed");
// Next-cycle implication, checked outside reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rmq assertion failed");
`endif

// ===== design/rmq_pkg.sv =====
// Shared types for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;
   typedef enum logic [1:0] {LEAD_W, LEAD_X, LEAD_Y, LEAD_Z} lead_type;
endpackage

// ===== design/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband vector alongside the data; uses rmq_pkg.
module rmq_sqrt #(
   parameter int VW  = 32,
   parameter int SBW = 8,
   parameter int HW  = (VW + 1) / 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [VW-1:0]  in_rad,
   input  logic [SBW-1:0] in_sb,
   output logic           out_valid,
   output logic [HW-1:0]  out_root,
   output logic [SBW-1:0] out_sb
);
   import rmq_pkg::*;
   localparam int PW = 2 * HW;

   logic [PW-1:0]  v_ff    [HW];
   logic [HW:0]    rem_ff  [HW];
   logic [HW-1:0]  root_ff [HW];
   logic           vld_ff  [HW];
   logic [SBW-1:0] sb_ff   [HW];

   for (genvar i = 0; i < HW; i++) begin : g_stage
      logic [PW-1:0]  v_src;
      logic [HW:0]    rem_src;
      logic [HW-1:0]  root_src;
      logic           vld_src;
      logic [SBW-1:0] sb_src;
      logic [HW+2:0]  tmp;
      logic [HW+2:0]  trial;
      logic [HW+2:0]  diff;
      logic           ge;
      if (i == 0) begin : g_first
         assign v_src    = PW'(in_rad);
         assign rem_src  = '0;
         assign root_src = '0;
         assign vld_src  = in_valid;
         assign sb_src   = in_sb;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign vld_src  = vld_ff[i-1];
         assign sb_src   = sb_ff[i-1];
      end
      assign tmp   = {rem_src, v_src[PW-1:PW-2]};
      assign trial = {1'b0, root_src, 2'b01};
      assign diff  = tmp - trial;
      assign ge    = tmp >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[i]    <= {v_src[PW-3:0], 2'b00};
            rem_ff[i]  <= ge ? diff[HW:0] : tmp[HW:0];
            root_ff[i] <= {root_src[HW-2:0], ge};
            sb_ff[i]   <= sb_src;
         end
      end
   end

   assign out_valid = vld_ff[HW-1];
   assign out_root  = root_ff[HW-1];
   assign out_sb    = sb_ff[HW-1];
endmodule

// ===== design/rmq_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per register stage. Carries a sideband vector; uses rmq_pkg.
module rmq_div #(
   parameter int DNW = 17,
   parameter int DVW = 31,
   parameter int SBW = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [2:0][DVW-1:0]      in_num,
   input  logic [DNW-1:0]           in_den,
   input  logic [SBW-1:0]           in_sb,
   output logic                     out_valid,
   output logic [2:0][DVW-1:0]      out_quo,
   output logic [SBW-1:0]           out_sb
);
   import rmq_pkg::*;

   logic [2:0][DNW-1:0] rem_ff [DVW];
   logic [2:0][DVW-1:0] dvd_ff [DVW];
   logic [2:0][DVW-1:0] quo_ff [DVW];
   logic [DNW-1:0]      den_ff [DVW];
   logic                vld_ff [DVW];
   logic [SBW-1:0]      sb_ff  [DVW];

   for (genvar i = 0; i < DVW; i++) begin : g_stage
      logic [2:0][DNW-1:0] rem_src;
      logic [2:0][DVW-1:0] dvd_src;
      logic [2:0][DVW-1:0] quo_src;
      logic [DNW-1:0]      den_src;
      logic                vld_src;
      logic [SBW-1:0]      sb_src;
      logic [2:0][DNW-1:0] rem_in;
      logic [2:0][DVW-1:0] quo_in;
      if (i == 0) begin : g_first
         assign rem_src = '0;
         assign dvd_src = in_num;
         assign quo_src = '0;
         assign den_src = in_den;
         assign vld_src = in_valid;
         assign sb_src  = in_sb;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign dvd_src = dvd_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign den_src = den_ff[i-1];
         assign vld_src = vld_ff[i-1];
         assign sb_src  = sb_ff[i-1];
      end
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [DNW:0] shifted;
         logic [DNW:0] diff;
         logic         ge;
         assign shifted   = {rem_src[k], dvd_src[k][DVW-1]};
         assign diff      = shifted - {1'b0, den_src};
         assign ge        = shifted >= {1'b0, den_src};
         assign rem_in[k] = ge ? diff[DNW-1:0] : shifted[DNW-1:0];
         assign quo_in[k] = {quo_src[k][DVW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
            den_ff[i] <= den_src;
            sb_ff[i]  <= sb_src;
            for (int k = 0; k < 3; k++) begin
               dvd_ff[i][k] <= {dvd_src[k][DVW-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = vld_ff[DVW-1];
   assign out_quo   = quo_ff[DVW-1];
   assign out_sb    = sb_ff[DVW-1];
endmodule

// ===== design/rotation_matrix_to_quaternion_top.sv =====
// Rotation matrix to quaternion (Shepperd's method) in fixed point. A new
// transaction is taken every cycle unless the output stalls; each passes through
// an input register, the square root pipeline (one stage per root bit, HW), the
// divider pipeline (one stage per quotient bit, DVW = WORD_BITS + 1 + FRAC_BITS)
// and an output register. A held stall on the output freezes the whole pipeline
// and stalls the input. A nonpositive radicand gives a zero quaternion with
// bad_radicand set. Uses rmq_pkg, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion_top #(
   parameter int WORD_BITS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_r00,
   input  logic signed [WORD_BITS-1:0] req_r01,
   input  logic signed [WORD_BITS-1:0] req_r02,
   input  logic signed [WORD_BITS-1:0] req_r10,
   input  logic signed [WORD_BITS-1:0] req_r11,
   input  logic signed [WORD_BITS-1:0] req_r12,
   input  logic signed [WORD_BITS-1:0] req_r20,
   input  logic signed [WORD_BITS-1:0] req_r21,
   input  logic signed [WORD_BITS-1:0] req_r22,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_quat_x,
   output logic signed [WORD_BITS-1:0] rsp_quat_y,
   output logic signed [WORD_BITS-1:0] rsp_quat_z,
   output logic signed [WORD_BITS-1:0] rsp_quat_w,
   output logic                        rsp_bad_radicand
);
   import rmq_pkg::*;
   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int RW   = ((W > F) ? W : F) + 3;
   localparam int VW   = RW - 1 + F;
   localparam int HW   = (VW + 1) / 2;
   localparam int MW   = W + 1;
   localparam int DVW  = MW + F;
   localparam int DNW  = HW + 1;
   localparam int SB1W = 2 + 1 + 3 + 3 * MW;
   localparam int SB2W = 2 + 1 + 3 + HW;
   localparam logic [DVW-1:0] MAXP = DVW'({(W-1){1'b1}});
   localparam logic [DVW-1:0] MAXN = DVW'({1'b1, {(W-1){1'b0}}});

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   logic signed [RW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   logic signed [RW-1:0] one, tr, rad_in;
   logic signed [RW-1:0] n_in [3];
   lead_type             lead_in;
   assign a00 = RW'(req_r00);
   assign a01 = RW'(req_r01);
   assign a02 = RW'(req_r02);
   assign a10 = RW'(req_r10);
   assign a11 = RW'(req_r11);
   assign a12 = RW'(req_r12);
   assign a20 = RW'(req_r20);
   assign a21 = RW'(req_r21);
   assign a22 = RW'(req_r22);
   assign one = RW'({1'b1, {F{1'b0}}});
   assign tr  = a00 + a11 + a22;

   always_comb begin
      if (tr > 0) begin
         lead_in = LEAD_W;
         rad_in  = tr + one;
         n_in[0] = a21 - a12;
         n_in[1] = a02 - a20;
         n_in[2] = a10 - a01;
      end else if (a00 > a11 && a00 > a22) begin
         lead_in = LEAD_X;
         rad_in  = one + a00 - a11 - a22;
         n_in[0] = a21 - a12;
         n_in[1] = a01 + a10;
         n_in[2] = a02 + a20;
      end else if (a11 > a22) begin
         lead_in = LEAD_Y;
         rad_in  = one + a11 - a00 - a22;
         n_in[0] = a02 - a20;
         n_in[1] = a01 + a10;
         n_in[2] = a12 + a21;
      end else begin
         lead_in = LEAD_Z;
         rad_in  = one + a22 - a00 - a11;
         n_in[0] = a10 - a01;
         n_in[1] = a02 + a20;
         n_in[2] = a12 + a21;
      end
   end

   logic                 s0_vld_ff;
   lead_type             s0_lead_ff;
   logic signed [RW-1:0] s0_rad_ff;
   logic signed [RW-1:0] s0_n_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s0_lead_ff <= lead_in;
         s0_rad_ff  <= rad_in;
         s0_n_ff    <= n_in;
      end
   end

   logic              s0_bad;
   logic [2:0]        s0_neg;
   logic [2:0][MW-1:0] s0_mag;
   logic [VW-1:0]     sq_rad;
   assign s0_bad = (s0_rad_ff <= 0);
   assign sq_rad = s0_bad ? '0 : {s0_rad_ff[RW-2:0], {F{1'b0}}};
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s0_neg[k] = s0_n_ff[k][RW-1];
         s0_mag[k] = s0_neg[k] ? MW'(-s0_n_ff[k]) : MW'(s0_n_ff[k]);
      end
   end

   logic              sq_vld;
   logic [HW-1:0]     sq_root;
   logic [SB1W-1:0]   sq_sb;
   lead_type          sq_lead;
   logic              sq_bad;
   logic [2:0]        sq_neg;
   logic [2:0][MW-1:0] sq_mag;

   rmq_sqrt #(.VW(VW), .SBW(SB1W), .HW(HW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s0_vld_ff),
      .in_rad   (sq_rad),
      .in_sb    ({s0_lead_ff, s0_bad, s0_neg, s0_mag}),
      .out_valid(sq_vld),
      .out_root (sq_root),
      .out_sb   (sq_sb)
   );
   assign {sq_lead, sq_bad, sq_neg, sq_mag} = sq_sb;

   logic [2:0][DVW-1:0] dv_num;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dv_num[k] = {sq_mag[k], {F{1'b0}}};
      end
   end

   logic                dv_vld;
   logic [2:0][DVW-1:0] dv_quo;
   logic [SB2W-1:0]     dv_sb;
   lead_type            dv_lead;
   logic                dv_bad;
   logic [2:0]          dv_neg;
   logic [HW-1:0]       dv_root;

   rmq_div #(.DNW(DNW), .DVW(DVW), .SBW(SB2W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_vld),
      .in_num   (dv_num),
      .in_den   ({sq_root, 1'b0}),
      .in_sb    ({sq_lead, sq_bad, sq_neg, sq_root}),
      .out_valid(dv_vld),
      .out_quo  (dv_quo),
      .out_sb   (dv_sb)
   );
   assign {dv_lead, dv_bad, dv_neg, dv_root} = dv_sb;

   function automatic logic [W-1:0] sat_word(input logic neg, input logic [DVW-1:0] mag);
      logic [DVW-1:0] m;
      if (neg) begin
         m = (mag > MAXN) ? MAXN : mag;
         m = -m;
      end else begin
         m = (mag > MAXP) ? MAXP : mag;
      end
      return m[W-1:0];
   endfunction

   logic [W-1:0] diag, c0, c1, c2;
   logic [W-1:0] x_in, y_in, z_in, w_in;
   assign diag = sat_word(1'b0, DVW'(dv_root >> 1));
   assign c0   = sat_word(dv_neg[0], dv_quo[0]);
   assign c1   = sat_word(dv_neg[1], dv_quo[1]);
   assign c2   = sat_word(dv_neg[2], dv_quo[2]);

   always_comb begin
      case (dv_lead)
         LEAD_W: begin
            w_in = diag; x_in = c0; y_in = c1; z_in = c2;
         end
         LEAD_X: begin
            w_in = c0; x_in = diag; y_in = c1; z_in = c2;
         end
         LEAD_Y: begin
            w_in = c0; x_in = c1; y_in = diag; z_in = c2;
         end
         default: begin
            w_in = c0; x_in = c1; y_in = c2; z_in = diag;
         end
      endcase
      if (dv_bad) begin
         w_in = '0; x_in = '0; y_in = '0; z_in = '0;
      end
   end

   logic         rsp_valid_ff;
   logic [W-1:0] quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;
   logic         bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         quat_x_ff <= x_in;
         quat_y_ff <= y_in;
         quat_z_ff <= z_in;
         quat_w_ff <= w_in;
         bad_ff    <= dv_bad;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quat_x       = quat_x_ff;
   assign rsp_quat_y       = quat_y_ff;
   assign rsp_quat_z       = quat_z_ff;
   assign rsp_quat_w       = quat_w_ff;
   assign rsp_bad_radicand = bad_ff;
endmodule

// ===== design/rmq_check.sv =====
// Port-level checker for the rotation matrix to quaternion block, with its bind.
// Depends on rotation_matrix_to_quaternion_top_assert.svh.
`include "rotation_matrix_to_quaternion_top_assert.svh"
module rmq_check #(
   parameter int WORD_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-1:0] rsp_quat_x,
   input logic [WORD_BITS-1:0] rsp_quat_y,
   input logic [WORD_BITS-1:0] rsp_quat_z,
   input logic [WORD_BITS-1:0] rsp_quat_w,
   input logic                 rsp_bad_radicand
);
   // A transaction with a bad radicand carries an all-zero quaternion.
   `RMQ_ASSERT_NOW(a_bad_zero, rsp_valid && rsp_bad_radicand, rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0 && rsp_quat_w == 0)
   // The input stalls only when a finished transaction is held at the output.
   `RMQ_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   // A held result stays valid and keeps its x, w and bad-radicand outputs.
   `RMQ_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_w) && $stable(rsp_bad_radicand))
endmodule

bind rotation_matrix_to_quaternion_top rmq_check #(.WORD_BITS(WORD_BITS)) u_rmq_check (.*);
